>>> design/lswc_pkg.sv
// Package with the widths and types shared by the line segment window clipper.
package lswc_pkg;

    // Width of one coordinate, two's complement.
    localparam int COORD_BITS = 16;
    // Width of a coordinate difference.
    localparam int DELTA_BITS = COORD_BITS + 1;
    // Width of a product of two differences.
    localparam int PROD_BITS  = 2 * DELTA_BITS;
    // Width of a sum of two such products.
    localparam int SUM_BITS   = PROD_BITS + 1;
    // Number of divider stages, one quotient bit each.
    localparam int DIV_STAGES = COORD_BITS;
    // Number of clipped coordinates per segment.
    localparam int LANES      = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Reset values of the window.
    localparam logic signed [COORD_BITS-1:0] WIN_LOW_RST  = COORD_BITS'(100);
    localparam logic signed [COORD_BITS-1:0] WIN_HIGH_RST = COORD_BITS'(700);

    // A line parameter held as an exact fraction n/d with d > 0.
    typedef struct packed {
        logic signed [DELTA_BITS-1:0] n;
        logic [COORD_BITS-1:0]        d;
    } t_frac;

endpackage

>>> design/line_segment_window_clipper_unit.sv
// Liang-Barsky line clipper: a deep pipeline with an exact rational datapath.
// The result reaches the output register through eight arithmetic stages,
// one restoring divider stage per quotient bit, and one output stage.
// Throughput is one item per cycle; the whole pipeline holds only while a result waits.
// Reset (synchronous, active low) clears all valid bits and loads the window
// with left 100, right 700, bottom 100, top 700.
module line_segment_window_clipper_unit
    import lswc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic signed [COORD_BITS-1:0] o_clip_start_x,
    output logic signed [COORD_BITS-1:0] o_clip_start_y,
    output logic signed [COORD_BITS-1:0] o_clip_end_x,
    output logic signed [COORD_BITS-1:0] o_clip_end_y
);

    localparam int CW = COORD_BITS;
    localparam int DW = DELTA_BITS;

    // Window registers.
    logic signed [CW-1:0] r_left, r_right, r_bottom, r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= WIN_LOW_RST;
            r_right  <= WIN_HIGH_RST;
            r_bottom <= WIN_LOW_RST;
            r_top    <= WIN_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                default:    r_left   <= r_left;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is held.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Valid bits of the arithmetic stages.
    logic [8:1] r_vld;

    // Stage 1: differences and edge distances.
    logic signed [CW-1:0] r1_xs, r1_ys;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_qx0, r1_qx1, r1_qy0, r1_qy1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xs  <= i_start_x;
            r1_ys  <= i_start_y;
            r1_dx  <= DW'(i_end_x) - DW'(i_start_x);
            r1_dy  <= DW'(i_end_y) - DW'(i_start_y);
            r1_qx0 <= DW'(i_start_x) - DW'(r_left);
            r1_qx1 <= DW'(r_right) - DW'(i_start_x);
            r1_qy0 <= DW'(i_start_y) - DW'(r_bottom);
            r1_qy1 <= DW'(r_top) - DW'(i_start_y);
        end
    end

    // Stage 2: entry and exit fractions per axis, entry clamped at 0 and exit at 1.
    t_frac n_ent_x, n_ent_y, n_ext_x, n_ext_y;
    logic  n_rej;
    logic signed [DW-1:0] neg_dx, neg_dy;
    t_frac r2_ent_x, r2_ent_y, r2_ext_x, r2_ext_y;
    logic  r2_rej;
    logic signed [CW-1:0] r2_xs, r2_ys;
    logic signed [DW-1:0] r2_dx, r2_dy;

    always_comb begin
        neg_dx = -r1_dx;
        neg_dy = -r1_dy;
        n_rej  = 1'b0;
        // X axis.
        if (r1_dx > 0) begin
            n_ent_x = '{n: -r1_qx0, d: r1_dx[CW-1:0]};
            n_ext_x = '{n: r1_qx1,  d: r1_dx[CW-1:0]};
        end else if (r1_dx < 0) begin
            n_ent_x = '{n: -r1_qx1, d: neg_dx[CW-1:0]};
            n_ext_x = '{n: r1_qx0,  d: neg_dx[CW-1:0]};
        end else begin
            n_ent_x = '{n: '0, d: CW'(1)};
            n_ext_x = '{n: DW'(1), d: CW'(1)};
            if (r1_qx0 < 0 || r1_qx1 < 0) n_rej = 1'b1;
        end
        // Y axis.
        if (r1_dy > 0) begin
            n_ent_y = '{n: -r1_qy0, d: r1_dy[CW-1:0]};
            n_ext_y = '{n: r1_qy1,  d: r1_dy[CW-1:0]};
        end else if (r1_dy < 0) begin
            n_ent_y = '{n: -r1_qy1, d: neg_dy[CW-1:0]};
            n_ext_y = '{n: r1_qy0,  d: neg_dy[CW-1:0]};
        end else begin
            n_ent_y = '{n: '0, d: CW'(1)};
            n_ext_y = '{n: DW'(1), d: CW'(1)};
            if (r1_qy0 < 0 || r1_qy1 < 0) n_rej = 1'b1;
        end
        // Entry below zero counts as zero, exit above one as one.
        if (n_ent_x.n <= 0) n_ent_x = '{n: '0, d: CW'(1)};
        if (n_ent_y.n <= 0) n_ent_y = '{n: '0, d: CW'(1)};
        if (n_ext_x.n >= $signed({1'b0, n_ext_x.d})) n_ext_x = '{n: DW'(1), d: CW'(1)};
        if (n_ext_y.n >= $signed({1'b0, n_ext_y.d})) n_ext_y = '{n: DW'(1), d: CW'(1)};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ent_x <= n_ent_x;
            r2_ent_y <= n_ent_y;
            r2_ext_x <= n_ext_x;
            r2_ext_y <= n_ext_y;
            r2_rej   <= n_rej;
            r2_xs    <= r1_xs;
            r2_ys    <= r1_ys;
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
        end
    end

    // Stage 3: cross products to order the two entries and the two exits.
    logic signed [PROD_BITS-1:0] r3_ea, r3_eb, r3_xa, r3_xb;
    t_frac r3_ent_x, r3_ent_y, r3_ext_x, r3_ext_y;
    logic  r3_rej;
    logic signed [CW-1:0] r3_xs, r3_ys;
    logic signed [DW-1:0] r3_dx, r3_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ea    <= PROD_BITS'(r2_ent_x.n) * PROD_BITS'($signed({1'b0, r2_ent_y.d}));
            r3_eb    <= PROD_BITS'(r2_ent_y.n) * PROD_BITS'($signed({1'b0, r2_ent_x.d}));
            r3_xa    <= PROD_BITS'(r2_ext_x.n) * PROD_BITS'($signed({1'b0, r2_ext_y.d}));
            r3_xb    <= PROD_BITS'(r2_ext_y.n) * PROD_BITS'($signed({1'b0, r2_ext_x.d}));
            r3_ent_x <= r2_ent_x;
            r3_ent_y <= r2_ent_y;
            r3_ext_x <= r2_ext_x;
            r3_ext_y <= r2_ext_y;
            r3_rej   <= r2_rej;
            r3_xs    <= r2_xs;
            r3_ys    <= r2_ys;
            r3_dx    <= r2_dx;
            r3_dy    <= r2_dy;
        end
    end

    // Stage 4: t1 is the later entry, t2 the earlier exit.
    t_frac r4_t1, r4_t2;
    logic  r4_rej;
    logic signed [CW-1:0] r4_xs, r4_ys;
    logic signed [DW-1:0] r4_dx, r4_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_t1  <= (r3_ea > r3_eb) ? r3_ent_x : r3_ent_y;
            r4_t2  <= (r3_xa < r3_xb) ? r3_ext_x : r3_ext_y;
            r4_rej <= r3_rej;
            r4_xs  <= r3_xs;
            r4_ys  <= r3_ys;
            r4_dx  <= r3_dx;
            r4_dy  <= r3_dy;
        end
    end

    // Stage 5: cross products of t1 and t2.
    logic signed [PROD_BITS-1:0] r5_g, r5_h;
    t_frac r5_t1, r5_t2;
    logic  r5_rej;
    logic signed [CW-1:0] r5_xs, r5_ys;
    logic signed [DW-1:0] r5_dx, r5_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_g   <= PROD_BITS'(r4_t1.n) * PROD_BITS'($signed({1'b0, r4_t2.d}));
            r5_h   <= PROD_BITS'(r4_t2.n) * PROD_BITS'($signed({1'b0, r4_t1.d}));
            r5_t1  <= r4_t1;
            r5_t2  <= r4_t2;
            r5_rej <= r4_rej;
            r5_xs  <= r4_xs;
            r5_ys  <= r4_ys;
            r5_dx  <= r4_dx;
            r5_dy  <= r4_dy;
        end
    end

    // Stage 6: the segment is kept when no edge rejects it and t1 < t2.
    logic  r6_acc;
    t_frac r6_t1, r6_t2;
    logic signed [CW-1:0] r6_xs, r6_ys;
    logic signed [DW-1:0] r6_dx, r6_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_acc <= !r5_rej && (r5_g < r5_h);
            r6_t1  <= r5_t1;
            r6_t2  <= r5_t2;
            r6_xs  <= r5_xs;
            r6_ys  <= r5_ys;
            r6_dx  <= r5_dx;
            r6_dy  <= r5_dy;
        end
    end

    // Stage 7: numerator products start*d and n*delta for each lane.
    // Lanes are clipped start x, start y, end x, end y.
    logic signed [PROD_BITS-1:0] r7_pa [LANES];
    logic signed [PROD_BITS-1:0] r7_pb [LANES];
    logic [CW-1:0] r7_d1, r7_d2;
    logic          r7_acc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_pa[0] <= PROD_BITS'(r6_xs) * PROD_BITS'($signed({1'b0, r6_t1.d}));
            r7_pb[0] <= PROD_BITS'(r6_t1.n) * PROD_BITS'(r6_dx);
            r7_pa[1] <= PROD_BITS'(r6_ys) * PROD_BITS'($signed({1'b0, r6_t1.d}));
            r7_pb[1] <= PROD_BITS'(r6_t1.n) * PROD_BITS'(r6_dy);
            r7_pa[2] <= PROD_BITS'(r6_xs) * PROD_BITS'($signed({1'b0, r6_t2.d}));
            r7_pb[2] <= PROD_BITS'(r6_t2.n) * PROD_BITS'(r6_dx);
            r7_pa[3] <= PROD_BITS'(r6_ys) * PROD_BITS'($signed({1'b0, r6_t2.d}));
            r7_pb[3] <= PROD_BITS'(r6_t2.n) * PROD_BITS'(r6_dy);
            r7_d1    <= r6_t1.d;
            r7_d2    <= r6_t2.d;
            r7_acc   <= r6_acc;
        end
    end

    // Stage 8: signed numerator split into sign and magnitude for the divider.
    // For a kept segment the quotient fits CW bits, so the magnitude fits 2*CW bits.
    logic signed [SUM_BITS-1:0] n_num [LANES];
    logic signed [SUM_BITS-1:0] n_abs [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_num[l] = SUM_BITS'(r7_pa[l]) + SUM_BITS'(r7_pb[l]);
            n_abs[l] = n_num[l][SUM_BITS-1] ? -n_num[l] : n_num[l];
        end
    end

    // Divider pipeline: index 0 is loaded by stage 8, each later index adds one quotient bit.
    logic [CW-1:0]    r_dv_rem [DIV_STAGES+1][LANES];
    logic [CW-1:0]    r_dv_lo  [DIV_STAGES+1][LANES];
    logic [LANES-1:0] r_dv_neg [DIV_STAGES+1];
    logic [CW-1:0]    r_dv_d1  [DIV_STAGES+1];
    logic [CW-1:0]    r_dv_d2  [DIV_STAGES+1];
    logic             r_dv_acc [DIV_STAGES+1];
    logic [DIV_STAGES:1] r_dv_vld;

    // One restoring step per stage and lane.
    logic [CW:0]   n_trial [DIV_STAGES][LANES];
    logic [CW-1:0] n_dsr   [DIV_STAGES][LANES];
    logic          n_ge    [DIV_STAGES][LANES];
    logic [CW-1:0] n_rem   [DIV_STAGES][LANES];
    logic [CW-1:0] n_lo    [DIV_STAGES][LANES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int l = 0; l < LANES; l++) begin
                n_dsr[k][l]   = (l < 2) ? r_dv_d1[k] : r_dv_d2[k];
                n_trial[k][l] = {r_dv_rem[k][l], r_dv_lo[k][l][CW-1]};
                n_ge[k][l]    = n_trial[k][l] >= {1'b0, n_dsr[k][l]};
                n_rem[k][l]   = n_ge[k][l] ? CW'(n_trial[k][l] - {1'b0, n_dsr[k][l]})
                                           : n_trial[k][l][CW-1:0];
                n_lo[k][l]    = {r_dv_lo[k][l][CW-2:0], n_ge[k][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_dv_rem[0][l] <= n_abs[l][2*CW-1:CW];
                r_dv_lo[0][l]  <= n_abs[l][CW-1:0];
                r_dv_neg[0][l] <= n_num[l][SUM_BITS-1];
            end
            r_dv_d1[0]  <= r7_d1;
            r_dv_d2[0]  <= r7_d2;
            r_dv_acc[0] <= r7_acc;
            for (int k = 0; k < DIV_STAGES; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_dv_rem[k+1][l] <= n_rem[k][l];
                    r_dv_lo[k+1][l]  <= n_lo[k][l];
                end
                r_dv_neg[k+1] <= r_dv_neg[k];
                r_dv_d1[k+1]  <= r_dv_d1[k];
                r_dv_d2[k+1]  <= r_dv_d2[k];
                r_dv_acc[k+1] <= r_dv_acc[k];
            end
        end
    end

    // Output register: apply the sign, zero every field of a rejected segment.
    logic [CW-1:0] n_res [LANES];
    logic          r_out_vld;
    logic          r_acc;
    logic [CW-1:0] r_res [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!r_dv_acc[DIV_STAGES]) n_res[l] = '0;
            else if (r_dv_neg[DIV_STAGES][l]) n_res[l] = -r_dv_lo[DIV_STAGES][l];
            else n_res[l] = r_dv_lo[DIV_STAGES][l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc <= r_dv_acc[DIV_STAGES];
            for (int l = 0; l < LANES; l++) begin
                r_res[l] <= n_res[l];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[7:1], i_valid};
            r_dv_vld  <= {r_dv_vld[DIV_STAGES-1:1], r_vld[8]};
            r_out_vld <= r_dv_vld[DIV_STAGES];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_accepted     = r_acc;
    assign o_clip_start_x = $signed(r_res[0]);
    assign o_clip_start_y = $signed(r_res[1]);
    assign o_clip_end_x   = $signed(r_res[2]);
    assign o_clip_end_y   = $signed(r_res[3]);

endmodule

>>> sim/tb_line_segment_window_clipper_unit.sv
// Testbench for the Liang-Barsky line segment window clipper with a self-checking scoreboard.
`timescale 1ns / 100ps

module tb_line_segment_window_clipper_unit;
    import lswc_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_segment;

    typedef struct {
        logic   acc;
        t_coord csx;
        t_coord csy;
        t_coord cex;
        t_coord cey;
    } t_clip;

    // Scoreboard: keeps its own copy of the window and the clips still owed.
    class t_clip_scoreboard;
        t_coord win[4];
        t_clip  pending[$];
        int     mismatches;

        function new();
            win[REG_LEFT]   = WIN_LOW_RST;
            win[REG_RIGHT]  = WIN_HIGH_RST;
            win[REG_BOTTOM] = WIN_LOW_RST;
            win[REG_TOP]    = WIN_HIGH_RST;
            mismatches      = 0;
        endfunction

        // Sign of na/da - nb/db with positive denominators.
        function int ratio_order(longint na, longint da, longint nb, longint db);
            longint diff;
            diff = na * db - nb * da;
            return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
        endfunction

        // Exact start + (n/d)*delta, truncated toward zero.
        function t_coord point_on(longint st, longint dl, longint n, longint d);
            longint num;
            num = st * d + n * dl;
            return t_coord'(num / d);
        endfunction

        function t_clip clip_segment(t_segment s);
            longint xs, ys, dx, dy;
            longint p[4];
            longint q[4];
            longint n1, d1, n2, d2;
            bit     rej;
            t_clip  r;
            xs = s.sx; ys = s.sy;
            dx = longint'(s.ex) - xs;
            dy = longint'(s.ey) - ys;
            n1 = 0; d1 = 1; n2 = 1; d2 = 1; rej = 0;
            p[0] = -dx; q[0] = xs - longint'(win[REG_LEFT]);
            p[1] = dx;  q[1] = longint'(win[REG_RIGHT]) - xs;
            p[2] = -dy; q[2] = ys - longint'(win[REG_BOTTOM]);
            p[3] = dy;  q[3] = longint'(win[REG_TOP]) - ys;
            // Each edge narrows the entry or the exit parameter.
            for (int i = 0; i < 4; i++) begin
                if (p[i] == 0) begin
                    if (q[i] < 0) rej = 1;
                end else if (p[i] < 0) begin
                    if (ratio_order(-q[i], -p[i], n1, d1) > 0) begin
                        n1 = -q[i]; d1 = -p[i];
                    end
                end else begin
                    if (ratio_order(q[i], p[i], n2, d2) < 0) begin
                        n2 = q[i]; d2 = p[i];
                    end
                end
            end
            r = '{1'b0, '0, '0, '0, '0};
            if (!rej && ratio_order(n1, d1, n2, d2) < 0) begin
                r.acc = 1'b1;
                r.csx = point_on(xs, dx, n1, d1);
                r.csy = point_on(ys, dy, n1, d1);
                r.cex = point_on(xs, dx, n2, d2);
                r.cey = point_on(ys, dy, n2, d2);
            end
            return r;
        endfunction

        function void note_segment(t_segment s);
            pending.push_back(clip_segment(s));
        endfunction

        function void check_clip(t_clip got);
            t_clip want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: acc=%0d (%0d,%0d)-(%0d,%0d)",
                             got.acc, got.csx, got.csy, got.cex, got.cey);
                return;
            end
            want = pending.pop_front();
            if (got.acc !== want.acc || got.csx !== want.csx || got.csy !== want.csy ||
                got.cex !== want.cex || got.cey !== want.cey) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp acc=%0d (%0d,%0d)-(%0d,%0d)",
                              " got acc=%0d (%0d,%0d)-(%0d,%0d)"},
                             want.acc, want.csx, want.csy, want.cex, want.cey,
                             got.acc, got.csx, got.csy, got.cex, got.cey);
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    logic [1:0] i_cfg_addr;
    logic [COORD_BITS-1:0] i_cfg_data;
    logic   i_valid;
    logic   o_ready;
    t_coord i_start_x, i_start_y, i_end_x, i_end_y;
    logic   o_valid;
    logic   i_ready;
    logic   o_accepted;
    t_coord o_clip_start_x, o_clip_start_y, o_clip_end_x, o_clip_end_y;

    t_clip_scoreboard sb;
    bit quiet;
    bit hold_req;
    bit hold_done;
    int idle_cycles = 0;

    line_segment_window_clipper_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_accepted     (o_accepted),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

    // Clock with a 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        i_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && i_rst_n && $urandom_range(0, 7) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // Check every accepted result item; watchdog on cycles with no traffic.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_clip('{o_accepted, o_clip_start_x, o_clip_start_y,
                            o_clip_end_x, o_clip_end_y});
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000) begin
            $display("[line_segment_window_clipper_unit] ERROR");
            $finish;
        end
    end

    // Offer one segment and wait until it is taken.
    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_start_x = sx; i_start_y = sy; i_end_x = ex; i_end_y = ey;
        do @(posedge i_clk); while (!o_ready);
        sb.note_segment('{sx, sy, ex, ey});
        // Random gap after the item.
        if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
        end
    endtask

    // Wait until every owed result has come and the pipeline is empty.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_window(t_coord l, t_coord r, t_coord b, t_coord t);
        t_coord vals[4];
        vals = '{l, r, b, t};
        drain();
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1; i_cfg_addr = 2'(i); i_cfg_data = vals[i];
            @(posedge i_clk);
            sb.win[i] = vals[i];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_coord rand_coord(bit nearby);
        if (nearby) return t_coord'($urandom_range(0, 900)) - t_coord'(100);
        return t_coord'($urandom);
    endfunction

    task automatic random_segments(int count, bit nearby);
        for (int k = 0; k < count; k++)
            send_segment(rand_coord(nearby && $urandom_range(0, 3) != 0),
                         rand_coord(nearby && $urandom_range(0, 3) != 0),
                         rand_coord(nearby && $urandom_range(0, 3) != 0),
                         rand_coord(nearby && $urandom_range(0, 3) != 0));
    endtask

    // Main sequence: reset, directed cases, then random phases over several windows.
    initial begin
        t_coord a, b;
        sb = new();
        quiet = 1'b0; hold_req = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = REG_LEFT; i_cfg_data = '0;
        i_valid = 1'b0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed cases on the reset window.
        send_segment(200, 200, 600, 500);       // fully inside
        send_segment(0, 400, 800, 400);         // horizontal, crosses left and right
        send_segment(400, 0, 400, 800);         // vertical, crosses bottom and top
        send_segment(0, 0, 800, 800);           // diagonal through both corners
        send_segment(50, 0, 50, 800);           // parallel, left of the window
        send_segment(0, 750, 800, 750);         // parallel, above the window
        send_segment(0, 200, 200, 0);           // touches one corner only
        send_segment(300, 300, 300, 300);       // point inside
        send_segment(100, 700, 100, 700);       // point on a corner
        send_segment(900, 300, 900, 300);       // point outside
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 400, 32767, 401);
        send_segment(0, 0, 50, 50);             // fully outside
        send_segment(700, 100, 700, 700);       // lies on the right edge
        send_segment(13, 150, 777, 333);        // inexact truncation

        // Inverted window rejects everything.
        write_window(500, 200, 500, 200);
        send_segment(300, 300, 300, 300);
        send_segment(0, 0, 800, 800);
        send_segment(-32768, -32768, 32767, 32767);

        // Extreme full-range window.
        write_window(-32768, 32767, -32768, 32767);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, 32767, -32768, -32768);
        random_segments(150, 1'b0);

        // Reset-valued window, with a long receiver hold-off.
        write_window(100, 700, 100, 700);
        hold_req = 1'b1;
        random_segments(200, 1'b1);
        drain();
        random_segments(100, 1'b1);

        // Random windows, mostly well ordered.
        for (int ph = 0; ph < 3; ph++) begin
            a = t_coord'($urandom_range(0, 400)) - t_coord'(150);
            b = a + t_coord'($urandom_range(1, 500));
            write_window(a, b, a + t_coord'($urandom_range(0, 50)), b);
            random_segments(80, 1'b1);
        end
        write_window(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                     t_coord'($urandom));
        random_segments(60, 1'b0);

        // Single-point window and a final quiet stretch with no idling.
        write_window(400, 400, 400, 400);
        random_segments(40, 1'b1);
        write_window(100, 700, 100, 700);
        quiet = 1'b1;
        random_segments(100, 1'b1);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[line_segment_window_clipper_unit] OK");
        else
            $display("[line_segment_window_clipper_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
design/lswc_pkg.sv
design/line_segment_window_clipper_unit.sv
sim/tb_line_segment_window_clipper_unit.sv
